// ===== rtl/assert_macros.svh =====
// ----------------------------------------------------------------------------
// Assertion macros
// Shared concurrent assertion helpers; define NO_ASSERTIONS to drop them.
// ----------------------------------------------------------------------------
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH
`ifndef NO_ASSERTIONS
// Same-cycle implication under an active-low reset
`define DTPT_ASSERT_IMP(lbl, clk, rstn, ante, cons, msg) \
  lbl: assert property (@(posedge clk) disable iff (!rstn) (ante) |-> (cons)) else $error(msg);
// Next-cycle implication under an active-low reset
`define DTPT_ASSERT_NXT(lbl, clk, rstn, ante, cons, msg) \
  lbl: assert property (@(posedge clk) disable iff (!rstn) (ante) |=> (cons)) else $error(msg);
`else
`define DTPT_ASSERT_IMP(lbl, clk, rstn, ante, cons, msg)
`define DTPT_ASSERT_NXT(lbl, clk, rstn, ante, cons, msg)
`endif
`endif

// ===== rtl/dtpt_pkg.sv =====
// ----------------------------------------------------------------------------
// Probe texel lookup package
// Constants, register codes, pipeline stage plan and arithmetic helpers.
// ----------------------------------------------------------------------------
package dtpt_pkg;

  // Direction format: signed Q1.14, converted to Q1.16 by a left shift of two
  localparam int DirW     = 16;
  localparam int DirFrac  = 14;
  localparam int ResBits  = 12;
  localparam int SizeW    = 13;
  localparam logic signed [DirW-1:0] DirOne = 16'sd16384;
  localparam logic [16:0] Q16One = 17'd65536;

  // acos(t)/pi polynomial coefficients, Q0.30
  localparam logic [31:0] K0 = 32'd536847842;
  localparam logic [31:0] K1 = 32'd72497033;
  localparam logic [31:0] K2 = 32'd25381120;
  localparam logic [31:0] K3 = 32'd6401348;

  // Configuration register indexes
  localparam logic [1:0] CfgMapMode = 2'd0;
  localparam logic [1:0] CfgWidth   = 2'd1;
  localparam logic [1:0] CfgHeight  = 2'd2;

  // Stage plan
  localparam int StDSqrtLo = 1;   // heading root, 32 steps
  localparam int StDSqrtHi = 32;
  localparam int StSSqrtHi = 17;  // sqrt(1-t), 17 steps from stage 1
  localparam int StPolyHi  = 3;   // Horner, stages 1..3
  localparam int StRadius  = 18;
  localparam int StProd    = 19;
  localparam int StDivLo   = 33;  // quotient, 17 steps
  localparam int StDivHi   = 49;
  localparam int StUv      = 50;
  localparam int StIndex   = 51;
  localparam int NumStages = 52;

  typedef struct packed {
    logic              map_mode;
    logic [SizeW-1:0]  width;
    logic [SizeW-1:0]  height;
  } cfg_t;

  typedef struct packed {
    logic [63:0] rem;
    logic [63:0] root;
  } sq_t;

  typedef struct packed {
    logic               x_neg;
    logic               y_neg;
    logic               z_neg;
    logic [15:0]        x_mag;
    logic [15:0]        y_mag;
    logic [16:0]        t;
    logic [63:0]        d_rem;
    logic [63:0]        d_root;
    logic [63:0]        s_rem;
    logic [63:0]        s_root;
    logic [31:0]        poly;
    logic [16:0]        r;
    logic [31:0]        px;
    logic [31:0]        py;
    logic [48:0]        qx_rem;
    logic [48:0]        qy_rem;
    logic [16:0]        qx;
    logic [16:0]        qy;
    logic [16:0]        u;
    logic [16:0]        v;
    logic [ResBits-1:0] row;
    logic [ResBits-1:0] col;
  } pipe_t;

  // 32 x 32 unsigned product
  function automatic logic [63:0] umul(logic [31:0] a, logic [31:0] b);
    logic [63:0] p;
    p = {32'd0, a} * {32'd0, b};
    return p;
  endfunction

  // One digit of the shift-and-subtract integer square root
  function automatic sq_t sqrt_step(logic [63:0] rem, logic [63:0] root,
                                    logic [63:0] bitv);
    sq_t         o;
    logic [64:0] trial;
    trial = {1'b0, root} + {1'b0, bitv};
    if ({1'b0, rem} >= trial) begin
      o.rem  = rem - trial[63:0];
      o.root = (root >> 1) + bitv;
    end else begin
      o.rem  = rem;
      o.root = root >> 1;
    end
    return o;
  endfunction

  // Scale a Q1.16 coordinate to an index, saturating at the index range
  function automatic logic [ResBits-1:0] scale_index(logic [SizeW-1:0] size,
                                                     logic [16:0] c);
    logic [SizeW-1:0] span;
    logic [63:0]      p;
    span = (size == '0) ? '0 : size - SizeW'(1);
    p    = umul(32'(span), 32'(c));
    if (p[63:16] > 48'((1 << ResBits) - 1)) begin
      return '1;
    end
    return p[ResBits+15:16];
  endfunction

endpackage

// ===== rtl/dtpt_if.sv =====
// ----------------------------------------------------------------------------
// Probe texel lookup channels
// Valid/ready request channels for directions in and texel indexes out.
// ----------------------------------------------------------------------------
interface dtpt_dir_if;
  logic                     valid;
  logic                     ready;
  logic signed [15:0]       dir_x;
  logic signed [15:0]       dir_y;
  logic signed [15:0]       dir_z;
  modport source (output valid, dir_x, dir_y, dir_z, input ready);
  modport sink   (input valid, dir_x, dir_y, dir_z, output ready);
endinterface

interface dtpt_texel_if;
  logic        valid;
  logic        ready;
  logic [11:0] texel_row;
  logic [11:0] texel_column;
  modport source (output valid, texel_row, texel_column, input ready);
  modport sink   (input valid, texel_row, texel_column, output ready);
endinterface

// ===== rtl/direction_to_probe_texel_core.sv =====
// ----------------------------------------------------------------------------
// Direction to probe texel core
// Maps a unit direction to a row and column of an angular light-probe map.
// ----------------------------------------------------------------------------
// Usage:
//   dir_in carries one request per direction (signed Q1.14 x, y, z); texel_out
//   returns the texel row and column for it, in order, one result each.
//   The configuration port writes map mode (index 0), image width (1) and
//   image height (2); write it only while no request is in flight.
// Pipeline: one request per cycle while the result is not held. The
//   depth comes from the 32-step square root of x*x + y*y, followed by
//   the 17-step quotient of the texel offsets; each step is one register
//   stage.
// Reset: all stage valid bits clear, registers return to angular mode and
//   a 1024 x 1024 image.
// Stall: when the result is held by the receiver the whole pipeline
//   freezes and dir_in.ready drops; nothing is lost or repeated.
// ----------------------------------------------------------------------------
`include "assert_macros.svh"

module direction_to_probe_texel_core (
  input  logic                        clk_i,
  input  logic                        rst_ni,
  input  logic                        cfg_we_i,
  input  logic [1:0]                  cfg_idx_i,
  input  logic [dtpt_pkg::SizeW-1:0]  cfg_wdata_i,
  dtpt_dir_if.sink                    dir_in,
  dtpt_texel_if.source                texel_out
);

  localparam int Last = dtpt_pkg::NumStages - 1;

  dtpt_pkg::cfg_t  cfg;
  dtpt_pkg::pipe_t st_q [dtpt_pkg::NumStages];
  logic [dtpt_pkg::NumStages-1:0] vld_q;
  logic adv;

  dtpt_cfg u_cfg (
    .clk_i      (clk_i),
    .rst_ni     (rst_ni),
    .cfg_we_i   (cfg_we_i),
    .cfg_idx_i  (cfg_idx_i),
    .cfg_wdata_i(cfg_wdata_i),
    .cfg_o      (cfg)
  );

  // Advance everything unless the result is held
  assign adv          = !vld_q[Last] || texel_out.ready;
  assign dir_in.ready = adv;

  for (genvar k = 0; k < dtpt_pkg::NumStages; k++) begin : g_stg
    localparam int DSh = (k >= dtpt_pkg::StDSqrtLo && k <= dtpt_pkg::StDSqrtHi) ?
                         62 - 2 * (k - 1) : 0;
    localparam int SSh = (k >= 1 && k <= dtpt_pkg::StSSqrtHi) ? 32 - 2 * (k - 1) : 0;
    localparam int QSh = (k >= dtpt_pkg::StDivLo && k <= dtpt_pkg::StDivHi) ?
                         16 - (k - dtpt_pkg::StDivLo) : 0;
    localparam logic [63:0] DBit = 64'd1 << DSh;
    localparam logic [63:0] SBit = 64'd1 << SSh;

    dtpt_pkg::pipe_t nxt;

    if (k == 0) begin : g_prep
      logic signed [15:0] zc;
      logic [15:0]        zm;
      logic [63:0]        xx, yy;
      logic [16:0]        one_t;

      // Clamp z, fold in mode, square x and y
      always_comb begin
        nxt   = '0;
        zc    = dir_in.dir_z;
        if (zc > dtpt_pkg::DirOne) begin
          zc = dtpt_pkg::DirOne;
        end else if (zc < -dtpt_pkg::DirOne) begin
          zc = -dtpt_pkg::DirOne;
        end
        if (cfg.map_mode) begin
          zc = -zc;
        end
        zm        = zc[15] ? 16'(-zc) : 16'(zc);
        nxt.z_neg = zc[15];
        nxt.t     = 17'(zm) << (16 - dtpt_pkg::DirFrac);
        nxt.x_neg = dir_in.dir_x[15];
        nxt.y_neg = dir_in.dir_y[15];
        nxt.x_mag = dir_in.dir_x[15] ? 16'(-dir_in.dir_x) : 16'(dir_in.dir_x);
        nxt.y_mag = dir_in.dir_y[15] ? 16'(-dir_in.dir_y) : 16'(dir_in.dir_y);
        xx        = dtpt_pkg::umul(32'(nxt.x_mag), 32'(nxt.x_mag));
        yy        = dtpt_pkg::umul(32'(nxt.y_mag), 32'(nxt.y_mag));
        nxt.d_rem = {xx[31:0] + yy[31:0], 32'd0};
        one_t     = dtpt_pkg::Q16One - nxt.t;
        nxt.s_rem = {15'd0, one_t, 32'd0} >> 16;
      end
    end else begin : g_work
      dtpt_pkg::sq_t dstep, sstep;
      logic [63:0]   prod;
      logic [63:0]   prod_y;
      logic [31:0]   raw;
      logic [48:0]   dsor;
      logic [17:0]   sum_u, sum_v;

      always_comb begin
        nxt    = st_q[k-1];
        dstep  = '0;
        sstep  = '0;
        prod   = '0;
        prod_y = '0;
        raw    = '0;
        dsor   = '0;
        sum_u  = '0;
        sum_v  = '0;

        // Heading root digit
        if (k >= dtpt_pkg::StDSqrtLo && k <= dtpt_pkg::StDSqrtHi) begin
          dstep      = dtpt_pkg::sqrt_step(nxt.d_rem, nxt.d_root, DBit);
          nxt.d_rem  = dstep.rem;
          nxt.d_root = dstep.root;
        end

        // sqrt(1-t) digit
        if (k >= 1 && k <= dtpt_pkg::StSSqrtHi) begin
          sstep      = dtpt_pkg::sqrt_step(nxt.s_rem, nxt.s_root, SBit);
          nxt.s_rem  = sstep.rem;
          nxt.s_root = sstep.root;
        end

        // Horner steps of the acos polynomial
        if (k == 1) begin
          prod     = dtpt_pkg::umul(dtpt_pkg::K3, 32'(nxt.t));
          nxt.poly = dtpt_pkg::K2 - prod[47:16];
        end else if (k == 2) begin
          prod     = dtpt_pkg::umul(nxt.poly, 32'(nxt.t));
          nxt.poly = dtpt_pkg::K1 - prod[47:16];
        end else if (k == dtpt_pkg::StPolyHi) begin
          prod     = dtpt_pkg::umul(nxt.poly, 32'(nxt.t));
          nxt.poly = dtpt_pkg::K0 - prod[47:16];
        end

        // Radius, mirrored for a negative angle argument
        if (k == dtpt_pkg::StRadius) begin
          prod  = dtpt_pkg::umul(nxt.s_root[31:0], nxt.poly) + 64'(1 << 29);
          raw   = prod[61:30];
          nxt.r = nxt.z_neg ? dtpt_pkg::Q16One - raw[16:0] : raw[16:0];
        end

        // Scale magnitudes by the radius
        if (k == dtpt_pkg::StProd) begin
          prod   = dtpt_pkg::umul(32'(nxt.r), 32'(nxt.x_mag));
          prod_y = dtpt_pkg::umul(32'(nxt.r), 32'(nxt.y_mag));
          nxt.px = prod[31:0];
          nxt.py = prod_y[31:0];
        end

        // Quotient digit; the quotient never exceeds the radius
        if (k >= dtpt_pkg::StDivLo && k <= dtpt_pkg::StDivHi) begin
          if (k == dtpt_pkg::StDivLo) begin
            nxt.qx_rem = {1'b0, nxt.px, 16'd0};
            nxt.qy_rem = {1'b0, nxt.py, 16'd0};
            nxt.qx     = '0;
            nxt.qy     = '0;
          end
          dsor = {17'd0, nxt.d_root[31:0]} << QSh;
          if (nxt.qx_rem >= dsor) begin
            nxt.qx_rem  = nxt.qx_rem - dsor;
            nxt.qx[QSh] = 1'b1;
          end
          if (nxt.qy_rem >= dsor) begin
            nxt.qy_rem  = nxt.qy_rem - dsor;
            nxt.qy[QSh] = 1'b1;
          end
        end

        // Texture coordinates; zero heading gives the centre
        if (k == dtpt_pkg::StUv) begin
          if (nxt.d_root == '0) begin
            sum_u = 18'(dtpt_pkg::Q16One);
            sum_v = 18'(dtpt_pkg::Q16One);
          end else begin
            sum_u = nxt.x_neg ? 18'(dtpt_pkg::Q16One) - 18'(nxt.qx)
                              : 18'(dtpt_pkg::Q16One) + 18'(nxt.qx);
            sum_v = nxt.y_neg ? 18'(dtpt_pkg::Q16One) - 18'(nxt.qy)
                              : 18'(dtpt_pkg::Q16One) + 18'(nxt.qy);
          end
          nxt.u = sum_u[17:1];
          nxt.v = sum_v[17:1];
        end

        // Texel indexes
        if (k == dtpt_pkg::StIndex) begin
          nxt.row = dtpt_pkg::scale_index(cfg.height, nxt.v);
          nxt.col = dtpt_pkg::scale_index(cfg.width, nxt.u);
        end
      end
    end

    // Stage register: payload moves with its valid bit
    always_ff @(posedge clk_i) begin
      if (adv) begin
        st_q[k] <= nxt;
      end
    end

    always_ff @(posedge clk_i or negedge rst_ni) begin
      if (!rst_ni) begin
        vld_q[k] <= 1'b0;
      end else if (adv) begin
        if (k == 0) begin
          vld_q[k] <= dir_in.valid;
        end else begin
          vld_q[k] <= vld_q[k-1];
        end
      end
    end
  end

  assign texel_out.valid        = vld_q[Last];
  assign texel_out.texel_row    = st_q[Last].row;
  assign texel_out.texel_column = st_q[Last].col;

  `DTPT_ASSERT_IMP(a_hold_blocks_input, clk_i, rst_ni, texel_out.valid && !texel_out.ready, !dir_in.ready, "input taken while result held")
  `DTPT_ASSERT_NXT(a_accept_enters, clk_i, rst_ni, dir_in.valid && dir_in.ready, vld_q[0], "accepted request lost at entry")
  `DTPT_ASSERT_IMP(a_radius_range, clk_i, rst_ni, vld_q[dtpt_pkg::StRadius], st_q[dtpt_pkg::StRadius].r <= dtpt_pkg::Q16One, "radius above one")
  `DTPT_ASSERT_IMP(a_coord_range, clk_i, rst_ni, vld_q[dtpt_pkg::StUv], (st_q[dtpt_pkg::StUv].u <= dtpt_pkg::Q16One) && (st_q[dtpt_pkg::StUv].v <= dtpt_pkg::Q16One), "coordinate above one")

endmodule

// ===== rtl/dtpt_cfg.sv =====
// ----------------------------------------------------------------------------
// Probe texel lookup configuration registers
// Decodes the write port into map mode and image size registers.
// ----------------------------------------------------------------------------
module dtpt_cfg (
  input  logic                        clk_i,
  input  logic                        rst_ni,
  input  logic                        cfg_we_i,
  input  logic [1:0]                  cfg_idx_i,
  input  logic [dtpt_pkg::SizeW-1:0]  cfg_wdata_i,
  output dtpt_pkg::cfg_t              cfg_o
);

  dtpt_pkg::cfg_t cfg_q, cfg_d;

  // Decode the write; unknown indexes are dropped
  always_comb begin
    cfg_d = cfg_q;
    if (cfg_we_i) begin
      unique case (cfg_idx_i)
        dtpt_pkg::CfgMapMode: cfg_d.map_mode = cfg_wdata_i[0];
        dtpt_pkg::CfgWidth:   cfg_d.width    = cfg_wdata_i;
        dtpt_pkg::CfgHeight:  cfg_d.height   = cfg_wdata_i;
        default: ;
      endcase
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      cfg_q.map_mode <= 1'b0;
      cfg_q.width    <= 13'd1024;
      cfg_q.height   <= 13'd1024;
    end else begin
      cfg_q <= cfg_d;
    end
  end

  assign cfg_o = cfg_q;

endmodule
